// File: hdl/hlcb_pkg.sv
package hlcb_pkg;

    localparam int MAX_LEN = 64;
    localparam int MAX_DIM = 3;

    localparam int IW = $clog2(MAX_LEN);      // residue index
    localparam int LW = $clog2(MAX_LEN + 1);  // residue count
    localparam int CW = $clog2(MAX_LEN) + 1;  // one signed axis

    localparam logic [2:0] REQ_PLACE      = 3'd0;
    localparam logic [2:0] REQ_REMOVE     = 3'd1;
    localparam logic [2:0] REQ_CHECK      = 3'd2;
    localparam logic [2:0] REQ_CLEAR      = 3'd3;
    localparam logic [2:0] REQ_CLEAR_CNT  = 3'd4;
    localparam logic [2:0] REQ_FOLD       = 3'd5;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_OVERLAP   = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_EMPTY     = 3'd3;
    localparam logic [2:0] STAT_BADMOVE   = 3'd4;

    typedef logic [MAX_DIM-1:0][CW-1:0] t_pos;
    typedef logic signed [2:0] t_move;

    typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_FOLD} t_state;
    typedef enum logic [1:0] {OP_PLACE, OP_REMOVE, OP_CHECK} t_op;

    // Query travelling down the chain, one cell per cycle.
    typedef struct packed {
        logic          valid;
        t_pos          target;
        logic          occ;
        logic [LW-1:0] cnt;
        t_pos          pick_a;
        t_pos          pick_b;
    } t_pkt;

    // Signals broadcast from the sequencer to every cell.
    typedef struct packed {
        logic [LW-1:0] occ_lim;
        logic [LW-1:0] con_lim;
        logic [IW-1:0] pick_a;
        logic [IW-1:0] pick_b;
        logic [1:0]    dims;
        logic          wr_pos_en;
        logic [IW-1:0] wr_pos_idx;
        t_pos          wr_pos;
        logic          wr_mv_en;
        logic [IW-1:0] wr_mv_idx;
        t_move         wr_mv;
        logic          fold_load;
        logic          fold_shift;
    } t_ctl;

endpackage

// File: hdl/hp_lattice_chain_builder.sv
// Channel   Direction  Beat contents
// s_*       in         tuser: req_type; tdata: move, count_change
// m_*       out        tdata: status .. fold_move; tlast: last
// APB       in/out     hydro_mask at 0x0, lattice_dims at 0x8
//
// Place and check walk the query along the cell row, one cell a cycle.
// Remove takes two walks, or none on a one-residue chain; clear and rejected requests answer without a walk.
// Fold readout gives one beat a cycle while the output is not stalled, from the move shift line, n - 1 beats in all.
// Reset clears the count, score, counter, head and control registers; residue cells reset only their query valid.
// A new request is taken only when idle and the result register is empty or being taken.
module hp_lattice_chain_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] move, [3] count_change, [7:4] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [2:0] status, [3] is_free, [12:4] energy,
                                   // [19:13] chain_length, [51:20] change_total,
                                   // [54:52] fold_move, [55] zero
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import hlcb_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_phase, n_phase;
    logic   r_launch, n_launch;
    t_pos   r_target, n_target;
    t_pos   r_prev, n_prev;
    t_pos   r_head, n_head;
    t_move  r_mv, n_mv;
    logic   r_track, n_track;
    logic [LW-1:0] r_count, n_count;
    logic signed [8:0] r_score, n_score;
    logic [31:0] r_total, n_total;
    logic [63:0] r_mask;
    logic [1:0]  r_dims;
    logic [LW-1:0] r_occ_lim, n_occ_lim;
    logic [LW-1:0] r_con_lim, n_con_lim;
    logic [LW-1:0] r_fold_k, n_fold_k;
    logic        r_ovalid, n_ovalid;
    logic [2:0]  r_ostatus, n_ostatus;
    logic        r_ofree, n_ofree;
    t_move       r_ofold, n_ofold;
    logic        r_olast, n_olast;

    t_ctl  w_ctl;
    t_pkt  w_pkt_in;
    t_pkt  w_pkt [MAX_LEN];
    t_move w_sh  [MAX_LEN];

    logic [1:0] w_du;
    t_move      w_in_mv;
    logic [2:0] w_mag;
    logic       w_mv_ok;
    t_pos       w_step;
    logic       w_acc;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? {62'd0, r_dims} : r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_dims <= 2'd2;
        end else if (psel && penable && pwrite) begin
            if (paddr[3])
                r_dims <= pwdata[1:0];
            else
                r_mask <= pwdata;
        end
    end

    assign w_du    = (r_dims == 2'd0) ? 2'd1 :
                     (int'(r_dims) > MAX_DIM) ? 2'(MAX_DIM) : r_dims;
    assign w_in_mv = t_move'(s_tdata[2:0]);
    assign w_mag   = w_in_mv[2] ? 3'(-w_in_mv) : 3'(w_in_mv);
    assign w_mv_ok = (w_in_mv != '0) && (w_mag <= {1'b0, w_du});
    assign w_acc   = s_tvalid && s_tready;
    assign s_tready = (r_state == ST_IDLE) && (!r_ovalid || m_tready);

    always_comb begin
        w_step = r_head;
        for (int k = 0; k < MAX_DIM; k++) begin
            if (int'(w_mag) == k + 1)
                w_step[k] = w_in_mv[2] ? r_head[k] - CW'(1) : r_head[k] + CW'(1);
        end
    end

    always_comb begin
        logic signed [9:0] s;
        logic [LW-1:0] q;
        n_state = r_state; n_op = r_op; n_phase = r_phase; n_launch = 1'b0;
        n_target = r_target; n_prev = r_prev; n_head = r_head; n_mv = r_mv;
        n_track = r_track; n_count = r_count; n_score = r_score; n_total = r_total;
        n_occ_lim = r_occ_lim; n_con_lim = r_con_lim; n_fold_k = r_fold_k;
        n_ovalid = r_ovalid && !m_tready;
        n_ostatus = r_ostatus; n_ofree = r_ofree; n_ofold = r_ofold; n_olast = r_olast;
        s = '0;
        q = r_count - LW'(1);

        w_ctl = '0;
        w_ctl.occ_lim = r_occ_lim;
        w_ctl.con_lim = r_con_lim;
        w_ctl.pick_a  = q[IW-1:0];
        w_ctl.pick_b  = IW'(r_count - LW'(2));
        w_ctl.dims    = w_du;

        w_pkt_in = '0;
        w_pkt_in.valid  = r_launch && (r_state == ST_SWEEP);
        w_pkt_in.target = r_target;

        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_ovalid = 1'b1; n_ostatus = STAT_OK; n_ofree = 1'b0;
                    n_ofold = '0; n_olast = 1'b1;
                    n_mv = w_in_mv; n_track = s_tdata[3];
                    if (s_tuser == REQ_PLACE) begin
                        if (int'(r_count) >= MAX_LEN) begin
                            n_ostatus = STAT_FULL;
                        end else if ((r_count == '0 && w_in_mv != '0) ||
                                     (r_count != '0 && !w_mv_ok)) begin
                            n_ostatus = STAT_BADMOVE;
                        end else begin
                            n_ovalid = 1'b0; n_state = ST_SWEEP; n_op = OP_PLACE;
                            n_launch = 1'b1;
                            n_target = (r_count == '0) ? r_head : w_step;
                            n_occ_lim = r_count;
                            n_con_lim = (r_count == '0) ? '0 : q;
                        end
                    end else if (s_tuser == REQ_REMOVE) begin
                        if (r_count == '0) begin
                            n_ostatus = STAT_EMPTY;
                        end else if (q == '0) begin
                            n_count = '0;
                        end else begin
                            n_ovalid = 1'b0; n_state = ST_SWEEP; n_op = OP_REMOVE;
                            n_phase = 1'b0; n_launch = 1'b1;
                            n_occ_lim = '0; n_con_lim = '0;
                        end
                    end else if (s_tuser == REQ_CHECK) begin
                        if (!w_mv_ok) begin
                            n_ostatus = STAT_BADMOVE;
                        end else begin
                            n_ovalid = 1'b0; n_state = ST_SWEEP; n_op = OP_CHECK;
                            n_launch = 1'b1; n_target = w_step;
                            n_occ_lim = r_count; n_con_lim = '0;
                        end
                    end else if (s_tuser == REQ_CLEAR || s_tuser == REQ_CLEAR_CNT) begin
                        n_count = '0; n_score = '0; n_head = '0;
                        if (s_tuser == REQ_CLEAR_CNT)
                            n_total = '0;
                    end else if (s_tuser == REQ_FOLD) begin
                        if (r_count >= LW'(2)) begin
                            n_ovalid = 1'b0; n_state = ST_FOLD; n_fold_k = '0;
                            w_ctl.fold_load = 1'b1;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                if (w_pkt[MAX_LEN-1].valid) begin
                    n_ovalid = 1'b1; n_ostatus = STAT_OK; n_ofree = 1'b0;
                    n_ofold = '0; n_olast = 1'b1; n_state = ST_IDLE;
                    unique case (r_op)
                        OP_PLACE: begin
                            if (w_pkt[MAX_LEN-1].occ) begin
                                n_ostatus = STAT_OVERLAP;
                            end else begin
                                if (r_count != '0 && r_mask[r_count[IW-1:0]]) begin
                                    s = 10'(r_score) - 10'(w_pkt[MAX_LEN-1].cnt);
                                    n_score = (s < -10'sd256) ? -9'sd256 : 9'(s);
                                end
                                w_ctl.wr_pos_en  = 1'b1;
                                w_ctl.wr_pos_idx = r_count[IW-1:0];
                                w_ctl.wr_pos     = r_target;
                                w_ctl.wr_mv_en   = (r_count != '0);
                                w_ctl.wr_mv_idx  = q[IW-1:0];
                                w_ctl.wr_mv      = r_mv;
                                n_head  = r_target;
                                n_count = r_count + LW'(1);
                                if (r_track && r_total != '1)
                                    n_total = r_total + 32'd1;
                            end
                        end
                        OP_CHECK: begin
                            n_ofree = !w_pkt[MAX_LEN-1].occ;
                        end
                        default: begin
                            if (!r_phase) begin
                                n_ovalid = 1'b0; n_state = ST_SWEEP;
                                n_phase = 1'b1; n_launch = 1'b1;
                                n_target = w_pkt[MAX_LEN-1].pick_a;
                                n_prev   = w_pkt[MAX_LEN-1].pick_b;
                                n_con_lim = r_count - LW'(2);
                            end else begin
                                if (r_mask[q[IW-1:0]]) begin
                                    s = 10'(r_score) + 10'(w_pkt[MAX_LEN-1].cnt);
                                    n_score = (s > 10'sd255) ? 9'sd255 : 9'(s);
                                end
                                n_head  = r_prev;
                                n_count = q;
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (!r_ovalid || m_tready) begin
                    n_ovalid = 1'b1; n_ostatus = STAT_OK; n_ofree = 1'b0;
                    n_ofold = w_sh[0];
                    n_olast = (r_fold_k == r_count - LW'(2));
                    n_fold_k = r_fold_k + LW'(1);
                    w_ctl.fold_shift = 1'b1;
                    if (n_olast)
                        n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
            r_phase  <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_score  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_fold_k <= '0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_phase  <= n_phase;
            r_head   <= n_head;
            r_count  <= n_count;
            r_score  <= n_score;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
            r_fold_k <= n_fold_k;
        end
        r_op      <= n_op;
        r_target  <= n_target;
        r_prev    <= n_prev;
        r_mv      <= n_mv;
        r_track   <= n_track;
        r_occ_lim <= n_occ_lim;
        r_con_lim <= n_con_lim;
        r_ostatus <= n_ostatus;
        r_ofree   <= n_ofree;
        r_ofold   <= n_ofold;
        r_olast   <= n_olast;
    end

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        t_pkt  w_in;
        t_move w_shin;
        if (g == 0) begin : g_first
            assign w_in = w_pkt_in;
        end else begin : g_mid
            assign w_in = w_pkt[g-1];
        end
        if (g == MAX_LEN - 1) begin : g_end
            assign w_shin = '0;
        end else begin : g_nxt
            assign w_shin = w_sh[g+1];
        end
        hlcb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IW'(g)),
            .i_hydro (r_mask[g]),
            .i_ctl   (w_ctl),
            .i_pkt   (w_in),
            .i_sh    (w_shin),
            .o_pkt   (w_pkt[g]),
            .o_sh    (w_sh[g])
        );
    end

    assign m_tvalid = r_ovalid;
    assign m_tlast  = r_olast;
    assign m_tdata  = {1'b0, r_ofold, r_total, r_count, r_score, r_ofree, r_ostatus};

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_LEN) else $error("chain length beyond capacity");
    a_tail_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pkt[MAX_LEN-1].valid |-> r_state == ST_SWEEP) else $error("stray query at tail");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> r_state == ST_IDLE) else $error("ready while busy");
    a_fold_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FOLD |-> r_count >= LW'(2)) else $error("fold on short chain");
`endif

endmodule

// File: hdl/hlcb_cell.sv
module hlcb_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [hlcb_pkg::IW-1:0] i_index,
    input  logic                  i_hydro,
    input  hlcb_pkg::t_ctl        i_ctl,
    input  hlcb_pkg::t_pkt        i_pkt,
    input  hlcb_pkg::t_move       i_sh,
    output hlcb_pkg::t_pkt        o_pkt,
    output hlcb_pkg::t_move       o_sh
);
    import hlcb_pkg::*;

    t_pos  r_pos;
    t_move r_move;
    t_move r_sh;
    t_pkt  r_pkt;
    t_pkt  n_pkt;

    logic  w_adj;

    // A neighbour differs by one on exactly one axis in use and agrees on all others.
    always_comb begin
        logic signed [CW:0] d;
        logic ok;
        logic one;
        ok  = 1'b1;
        one = 1'b0;
        for (int k = 0; k < MAX_DIM; k++) begin
            d = $signed({r_pos[k][CW-1], r_pos[k]}) - $signed({i_pkt.target[k][CW-1],
                                                               i_pkt.target[k]});
            if (d != '0) begin
                if ((d == (CW+1)'(1) || d == -(CW+1)'(1)) && (k < int'(i_ctl.dims)) && !one)
                    one = 1'b1;
                else
                    ok = 1'b0;
            end
        end
        w_adj = ok && one;
    end

    always_comb begin
        n_pkt = i_pkt;
        if (i_pkt.valid) begin
            if ({1'b0, i_index} < i_ctl.occ_lim && r_pos == i_pkt.target)
                n_pkt.occ = 1'b1;
            if (i_hydro && {1'b0, i_index} < i_ctl.con_lim && w_adj)
                n_pkt.cnt = i_pkt.cnt + LW'(1);
            if (i_index == i_ctl.pick_a)
                n_pkt.pick_a = r_pos;
            if (i_index == i_ctl.pick_b)
                n_pkt.pick_b = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt.valid <= 1'b0;
        end else begin
            r_pkt.valid <= n_pkt.valid;
        end
        r_pkt.target <= n_pkt.target;
        r_pkt.occ    <= n_pkt.occ;
        r_pkt.cnt    <= n_pkt.cnt;
        r_pkt.pick_a <= n_pkt.pick_a;
        r_pkt.pick_b <= n_pkt.pick_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_pos_en && i_ctl.wr_pos_idx == i_index)
            r_pos <= i_ctl.wr_pos;
        if (i_ctl.wr_mv_en && i_ctl.wr_mv_idx == i_index)
            r_move <= i_ctl.wr_mv;
        if (i_ctl.fold_load)
            r_sh <= r_move;
        else if (i_ctl.fold_shift)
            r_sh <= i_sh;
    end

    assign o_pkt = r_pkt;
    assign o_sh  = r_sh;

endmodule
